/* rtl/core/tcce_pkg.sv */
// Shared types and constants for the text console cell engine.
package tcce_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'd7;

    typedef enum logic [3:0] {
        OP_PUT        = 4'd0,
        OP_PUT_COLOR  = 4'd1,
        OP_OVR        = 4'd2,
        OP_OVR_COLOR  = 4'd3,
        OP_PUT_AT     = 4'd4,
        OP_UP         = 4'd5,
        OP_DOWN       = 4'd6,
        OP_LEFT       = 4'd7,
        OP_RIGHT      = 4'd8,
        OP_BACKSPACE  = 4'd9,
        OP_CLEAR      = 4'd10,
        OP_READ       = 4'd11
    } t_opcode;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic exec;
        logic walk;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_walk;
        logic walk_last;
    } t_sts;

endpackage

/* rtl/core/tcce_ctrl.sv */
// Controller state machine: command sequencing and output handshake.
module tcce_ctrl
    import tcce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_sts.walk_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_sts.need_walk ? ST_WALK : ST_DONE;
            end
            ST_WALK: begin
                if (i_sts.walk_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            ST_INIT: o_cmd.walk = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            ST_EXEC: o_cmd.exec = 1'b1;
            ST_WALK: o_cmd.walk = 1'b1;
            ST_DONE: o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/tcce_datapath.sv */
// Datapath: screen memory, cursor, text color, walk counter and result register.
module tcce_datapath
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_cell_color,
    input  logic [6:0]  i_target_col,
    input  logic [4:0]  i_target_row,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_text_color,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_position,
    output logic [15:0] o_cell_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int WW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam logic [AW-1:0] C_A        = AW'(COLUMNS);
    localparam logic [WW-1:0] WALK_END   = WW'(CELLS);
    localparam logic [WW-1:0] COPY_END   = WW'(CELLS - COLUMNS);
    localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);

    logic [15:0] mem [CELLS];
    logic [15:0] r_rdata;

    t_opcode     r_op;
    logic [7:0]  r_ch;
    logic [7:0]  r_color;
    logic [6:0]  r_tcol;
    logic [4:0]  r_trow;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [7:0]    r_text_color;
    logic [WW-1:0] r_walk;
    logic          r_walk_copy;
    logic [7:0]    r_walk_color;

    logic [AW-1:0] cur_addr, tgt_addr, st_addr, rd_addr, wr_addr, rd_walk;
    logic [15:0]   wr_data;
    logic [7:0]    cmd_color, st_ch;
    logic          tgt_in_range, st_en, need_walk, walk_copy, wr_en;
    logic          col_last, row_last, copy_rd, copy_wr, is_read;

    assign cur_addr     = AW'(r_row) * C_A + AW'(r_col);
    assign tgt_addr     = AW'(r_trow) * C_A + AW'(r_tcol);
    assign tgt_in_range = (32'(r_tcol) < COLUMNS) && (32'(r_trow) < ROWS);
    assign col_last     = r_col == COL_LAST;
    assign row_last     = r_row == ROW_LAST;
    assign is_read      = r_op == OP_READ;

    always_comb begin
        cmd_color = r_text_color;
        if (r_op == OP_PUT_COLOR || r_op == OP_OVR_COLOR || r_op == OP_PUT_AT) begin
            cmd_color = r_color;
        end
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        st_en     = 1'b0;
        st_addr   = cur_addr;
        st_ch     = r_ch;
        need_walk = 1'b0;
        walk_copy = 1'b1;
        unique case (r_op)
            OP_PUT, OP_PUT_COLOR: begin
                if (r_ch == NEWLINE_CODE) begin
                    n_col = '0;
                    if (row_last) need_walk = 1'b1;
                    else n_row = r_row + RW'(1);
                end else begin
                    st_en = 1'b1;
                    if (col_last) begin
                        n_col = '0;
                        if (row_last) need_walk = 1'b1;
                        else n_row = r_row + RW'(1);
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            OP_OVR, OP_OVR_COLOR: st_en = 1'b1;
            OP_PUT_AT: begin
                st_en   = tgt_in_range;
                st_addr = tgt_addr;
            end
            OP_UP: begin
                if (r_row != '0) n_row = r_row - RW'(1);
            end
            OP_DOWN: begin
                if (row_last) begin
                    need_walk = 1'b1;
                    n_col     = '0;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
            OP_LEFT: begin
                if (r_col != '0) n_col = r_col - CW'(1);
            end
            OP_RIGHT: begin
                if (!col_last) n_col = r_col + CW'(1);
            end
            OP_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col   = r_col - CW'(1);
                    st_en   = 1'b1;
                    st_addr = cur_addr - AW'(1);
                    st_ch   = SPACE_CODE;
                end
            end
            OP_CLEAR: begin
                need_walk = 1'b1;
                walk_copy = 1'b0;
                n_col     = '0;
                n_row     = '0;
            end
            default: n_col = r_col;
        endcase
    end

    // Walk step k reads cell k+COLUMNS and writes cell k-1 from the previous read.
    assign copy_rd = r_walk < COPY_END;
    assign copy_wr = r_walk_copy && (r_walk <= COPY_END);
    assign rd_walk = AW'(r_walk) + C_A;

    always_comb begin
        if (i_cmd.walk) begin
            rd_addr = copy_rd ? rd_walk : '0;
        end else begin
            rd_addr = tgt_in_range ? tgt_addr : '0;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = st_addr;
        wr_data = {cmd_color, st_ch};
        if (i_cmd.walk) begin
            wr_en   = r_walk != '0;
            wr_addr = AW'(r_walk - WW'(1));
            wr_data = copy_wr ? r_rdata : {r_walk_color, SPACE_CODE};
        end else if (i_cmd.exec) begin
            wr_en = st_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op    <= t_opcode'(i_opcode);
            r_ch    <= i_char_code;
            r_color <= i_cell_color;
            r_tcol  <= i_target_col;
            r_trow  <= i_target_row;
        end
        if (i_cmd.load_out) begin
            o_cursor_col      <= 7'(r_col);
            o_cursor_row      <= 5'(r_row);
            o_cursor_position <= 11'(cur_addr);
            o_cell_data       <= (is_read && tgt_in_range) ? r_rdata : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_text_color <= RESET_COLOR;
            r_walk       <= '0;
            r_walk_copy  <= 1'b0;
            r_walk_color <= RESET_COLOR;
        end else begin
            if (i_cfg_we) r_text_color <= i_text_color;
            if (i_cmd.exec) begin
                r_col        <= n_col;
                r_row        <= n_row;
                r_walk_copy  <= walk_copy;
                r_walk_color <= cmd_color;
            end
            if (i_cmd.walk) begin
                r_walk <= (r_walk == WALK_END) ? '0 : r_walk + WW'(1);
            end
        end
    end

    assign o_sts.need_walk = need_walk;
    assign o_sts.walk_last = r_walk == WALK_END;

`ifndef SYNTHESIS
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS))
        else $error("cursor left the screen");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk <= WALK_END)
        else $error("walk counter overran the screen");
    a_exec_not_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> !i_cmd.walk && !i_cmd.take)
        else $error("command execute overlaps walk or item take");
    a_walk_idle_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> r_walk == '0)
        else $error("walk counter not rewound before command");
`endif

endmodule

/* rtl/core/text_console_cell_engine.sv */
// Top level of the text console cell engine.
// Character-cell console of COLUMNS x ROWS 16-bit cells (character low byte,
// attribute high byte) with a cursor; each transaction on the input channel is
// one command and yields exactly one result transaction carrying the cursor
// after the command and, for a read, the cell. An ordinary command is taken,
// executed with one memory access and then loads the result register; the load
// waits until the output register is empty or its result is being taken, and
// the next command is taken after the load. A scroll or a clear walks the
// single-port-write screen memory one cell per cycle. After reset a clearing
// pass blanks the memory before the first command is taken; text color writes
// are taken at any time.
module text_console_cell_engine
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_cell_color,
    input  logic [6:0]  i_target_col,
    input  logic [4:0]  i_target_row,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_position,
    output logic [15:0] o_cell_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_text_color
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    tcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tcce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_opcode          (i_opcode),
        .i_char_code       (i_char_code),
        .i_cell_color      (i_cell_color),
        .i_target_col      (i_target_col),
        .i_target_row      (i_target_row),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_text_color      (i_text_color),
        .o_cursor_col      (o_cursor_col),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_position (o_cursor_position),
        .o_cell_data       (o_cell_data)
    );

endmodule

/* test/text_console_cell_engine_tb.sv */
// Self-checking testbench for the text console cell engine: directed and random commands.
module text_console_cell_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcce_pkg::*;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELLS         = COLUMNS * ROWS;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 275;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 2100;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 600;
    localparam logic [3:0] MOVE_OPS [5] = '{OP_UP, OP_DOWN, OP_LEFT, OP_RIGHT, OP_BACKSPACE};
    localparam logic [3:0] EDIT_OPS [3] = '{OP_OVR, OP_OVR_COLOR, OP_PUT_AT};

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] char_code;
        logic [7:0] cell_color;
        logic [6:0] target_col;
        logic [4:0] target_row;
    } console_cmd_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_position;
        logic [15:0] cell_data;
    } cursor_report_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  opcode = '0;
    logic [7:0]  char_code = '0;
    logic [7:0]  cell_color = '0;
    logic [6:0]  target_col = '0;
    logic [4:0]  target_row = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  text_color = '0;

    text_console_cell_engine dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_opcode          (opcode),
        .i_char_code       (char_code),
        .i_cell_color      (cell_color),
        .i_target_col      (target_col),
        .i_target_row      (target_row),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_cursor_col      (cursor_col),
        .o_cursor_row      (cursor_row),
        .o_cursor_position (cursor_position),
        .o_cell_data       (cell_data),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_text_color      (text_color)
    );

    // screen model
    logic [15:0] screen_model [CELLS];
    int          model_col;
    int          model_row;
    logic [7:0]  model_color;
    int          walks;

    console_cmd_t   pending_cmds [$];
    cursor_report_t expected_reports [$];
    console_cmd_t   cmd_now;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int tx_gap;
    int rx_gap;
    int hold_count;
    bit hold_done;
    int quiet_cycles;
    int cmds_taken;
    int results_seen;
    int colors_set;
    int err_count;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic fill_screen(input logic [7:0] color);
        for (int i = 0; i < CELLS; i++) screen_model[i] = {color, SPACE_CODE};
        walks++;
    endtask

    task automatic scroll_screen(input logic [7:0] color);
        for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {color, SPACE_CODE};
        model_row = ROWS - 1;
        model_col = 0;
        walks++;
    endtask

    task automatic next_row(input logic [7:0] color);
        model_row++;
        if (model_row >= ROWS) scroll_screen(color);
    endtask

    task automatic write_cell(input int col, input int row, input logic [7:0] ch,
                              input logic [7:0] color);
        if (col >= 0 && col < COLUMNS && row >= 0 && row < ROWS)
            screen_model[row * COLUMNS + col] = {color, ch};
    endtask

    task automatic type_char(input logic [7:0] ch, input logic [7:0] color);
        if (ch == NEWLINE_CODE) begin
            next_row(color);
            model_col = 0;
        end else begin
            write_cell(model_col, model_row, ch, color);
            model_col++;
            if (model_col >= COLUMNS) begin
                model_col = 0;
                next_row(color);
            end
        end
    endtask

    task automatic run_console(input console_cmd_t cmd, output cursor_report_t rep);
        logic [15:0] data;
        data = '0;
        case (cmd.opcode)
            OP_PUT:       type_char(cmd.char_code, model_color);
            OP_PUT_COLOR: type_char(cmd.char_code, cmd.cell_color);
            OP_OVR:       write_cell(model_col, model_row, cmd.char_code, model_color);
            OP_OVR_COLOR: write_cell(model_col, model_row, cmd.char_code, cmd.cell_color);
            OP_PUT_AT:    write_cell(cmd.target_col, cmd.target_row, cmd.char_code, cmd.cell_color);
            OP_UP: begin
                if (model_row > 0) model_row--;
            end
            OP_DOWN:      next_row(model_color);
            OP_LEFT: begin
                if (model_col > 0) model_col--;
            end
            OP_RIGHT: begin
                if (model_col + 1 < COLUMNS) model_col++;
            end
            OP_BACKSPACE: begin
                if (model_col > 0) begin
                    model_col--;
                    write_cell(model_col, model_row, SPACE_CODE, model_color);
                end
            end
            OP_CLEAR: begin
                fill_screen(model_color);
                model_col = 0;
                model_row = 0;
            end
            OP_READ: begin
                if (cmd.target_col < COLUMNS && cmd.target_row < ROWS)
                    data = screen_model[cmd.target_row * COLUMNS + cmd.target_col];
            end
            default: ;
        endcase
        rep.cursor_col      = 7'(model_col);
        rep.cursor_row      = 5'(model_row);
        rep.cursor_position = 11'(model_row * COLUMNS + model_col);
        rep.cell_data       = data;
    endtask

    function automatic int pick_gap(input bit enabled);
        if (!enabled) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic console_cmd_t random_cmd(input logic [3:0] op);
        console_cmd_t c;
        c.opcode     = op;
        c.char_code  = 8'($urandom);
        c.cell_color = 8'($urandom);
        c.target_col = 7'($urandom);
        c.target_row = 5'($urandom);
        return c;
    endfunction

    // mostly on screen, often the bottom row, sometimes anywhere the fields reach
    function automatic console_cmd_t with_target(input console_cmd_t c);
        if ($urandom_range(0, 6) != 0) begin
            c.target_col = 7'($urandom_range(0, COLUMNS - 1));
            c.target_row = ($urandom_range(0, 2) == 0) ? 5'(ROWS - 1)
                                                      : 5'($urandom_range(0, ROWS - 1));
        end
        return c;
    endfunction

    task automatic add_cmd(input logic [3:0] op, input logic [7:0] ch, input logic [7:0] color,
                           input logic [6:0] col, input logic [4:0] row);
        pending_cmds.push_back('{op, ch, color, col, row});
    endtask

    task automatic build_phase(input int count);
        console_cmd_t c;
        int           pick;
        int           len;
        logic [3:0]   run_op;
        while (pending_cmds.size() < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 40);
                for (int i = 0; i < len; i++) begin
                    c = random_cmd(($urandom_range(0, 3) == 0) ? OP_PUT_COLOR : OP_PUT);
                    if ($urandom_range(0, 7) != 0) c.char_code = 8'($urandom_range(32, 126));
                    pending_cmds.push_back(c);
                end
                if ($urandom_range(0, 9) < 7) begin
                    c = random_cmd(($urandom_range(0, 3) == 0) ? OP_PUT_COLOR : OP_PUT);
                    c.char_code = NEWLINE_CODE;
                    pending_cmds.push_back(c);
                end
            end else if (pick < 62) begin
                if ($urandom_range(0, 4) == 0) begin
                    run_op = MOVE_OPS[$urandom_range(0, 4)];
                    case (run_op)
                        OP_DOWN: len = $urandom_range(20, 27);
                        OP_UP:   len = $urandom_range(25, 30);
                        default: len = $urandom_range(80, 85);
                    endcase
                    repeat (len) pending_cmds.push_back(random_cmd(run_op));
                end else begin
                    repeat ($urandom_range(1, 6))
                        pending_cmds.push_back(random_cmd(MOVE_OPS[$urandom_range(0, 4)]));
                end
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 4)) pending_cmds.push_back(with_target(random_cmd(OP_READ)));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4))
                    pending_cmds.push_back(with_target(random_cmd(EDIT_OPS[$urandom_range(0, 2)])));
            end else if (pick < 94) begin
                pending_cmds.push_back(random_cmd(OP_CLEAR));
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1) == 0)
                        pending_cmds.push_back(random_cmd(4'($urandom)));
                    else
                        pending_cmds.push_back(random_cmd(OP_READ + 4'($urandom_range(1, 4))));
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // command driver
    always @(posedge clk) begin
        console_cmd_t   nxt_cmd;
        cursor_report_t rep;
        logic           nxt_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            nxt_valid = in_valid;
            if (in_valid && in_ready) begin
                run_console(cmd_now, rep);
                expected_reports.push_back(rep);
                cmds_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                end else if (pending_cmds.size() > 0) begin
                    nxt_cmd = pending_cmds.pop_front();
                    cmd_now    <= nxt_cmd;
                    opcode     <= nxt_cmd.opcode;
                    char_code  <= nxt_cmd.char_code;
                    cell_color <= nxt_cmd.cell_color;
                    target_col <= nxt_cmd.target_col;
                    target_row <= nxt_cmd.target_row;
                    tx_gap     <= pick_gap(tx_idle_on);
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // result monitor
    always @(posedge clk) begin
        cursor_report_t want;
        int             nxt_gap;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
        end else begin
            nxt_gap = rx_gap;
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_reports.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual col %0d row %0d data %h",
                             $time, cursor_col, cursor_row, cell_data);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("cursor_col", want.cursor_col, cursor_col);
                    check_field("cursor_row", want.cursor_row, cursor_row);
                    check_field("cursor_position", want.cursor_position, cursor_position);
                    check_field("cell_data", want.cell_data, cell_data);
                end
                nxt_gap = pick_gap(rx_idle_on);
            end else if (nxt_gap > 0) begin
                nxt_gap--;
            end
            rx_gap    <= nxt_gap;
            out_ready <= (nxt_gap == 0) && (hold_count == 0);
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_count <= 0;
            hold_done  <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_count <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // sampled mid-cycle so the driver and monitor updates of the last edge are settled
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    task automatic set_text_color(input logic [7:0] value);
        @(posedge clk);
        cfg_valid  <= 1'b1;
        text_color <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        model_color = value;
        colors_set++;
    endtask

    initial begin
        logic [7:0] phase_color;
        fill_screen(RESET_COLOR);
        walks       = 0;
        model_col   = 0;
        model_row   = 0;
        model_color = RESET_COLOR;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_READ, 8'hFF, 8'hFF, 7'(COLUMNS - 1), 5'(ROWS - 1));
        add_cmd(OP_READ, 8'h00, 8'h00, 7'h7F, 5'h1F);
        add_cmd(OP_READ, 8'h00, 8'h00, 7'(COLUMNS), 5'd0);
        add_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'(ROWS));
        add_cmd(OP_UP, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
        add_cmd(OP_LEFT, 8'h00, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_PUT, 8'h41, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_PUT_COLOR, 8'hFF, 8'hFF, 7'd0, 5'd0);
        add_cmd(OP_OVR, NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_OVR_COLOR, 8'h00, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_PUT_AT, 8'h5A, 8'h1E, 7'(COLUMNS - 1), 5'(ROWS - 1));
        add_cmd(OP_PUT_AT, 8'h21, 8'h4F, 7'(COLUMNS), 5'(ROWS - 1));
        add_cmd(OP_PUT_AT, 8'h22, 8'h4F, 7'd0, 5'(ROWS));
        add_cmd(OP_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1));
        add_cmd(OP_READ, 8'h00, 8'h00, 7'd2, 5'd0);
        add_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_RIGHT, 8'h00, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_DOWN, 8'h00, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_BACKSPACE, 8'h00, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_READ + 4'd4, 8'hFF, 8'hFF, 7'h7F, 5'h1F);
        add_cmd(OP_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
        add_cmd(OP_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1));
        add_cmd(OP_PUT_COLOR, NEWLINE_CODE, 8'hA5, 7'd0, 5'd0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       phase_color = 8'hFF;
                1:       phase_color = 8'h00;
                default: phase_color = 8'($urandom);
            endcase
            set_text_color(phase_color);
            tx_idle_on = (p == 0) || (p == 2) || (p == 4);
            rx_idle_on = (p == 0) || (p == 3) || (p == 4);
            build_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Ran %0d console commands under %0d text colors, %0d results checked.",
                 cmds_taken, colors_set + 1, results_seen);
        $display("Screen walks (scrolls and clears) predicted: %0d.", walks);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/tcce_pkg.sv
rtl/core/tcce_ctrl.sv
rtl/core/tcce_datapath.sv
rtl/core/text_console_cell_engine.sv
test/text_console_cell_engine_tb.sv
